>>> rtl/lnut_pkg.sv
// Types, constants and register indexes of the linear neuron update pipeline.
package lnut_pkg;

   localparam int VAR_COUNT_DEF = 2;
   localparam int SPIKE_VAR_DEF = 0;
   localparam int FRAC_BITS_DEF = 16;

   localparam int ID_W      = 10;
   localparam int WORD_W    = 32;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int CSR_IDX_W = 8;

   typedef logic        [ID_W-1:0]      id_type;
   typedef logic signed [WORD_W-1:0]    word_type;
   typedef logic signed [PROD_W-1:0]    prod_type;
   typedef logic        [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_COEF_A00        = 8'd0;
   localparam csr_idx_type REG_COEF_A01        = 8'd1;
   localparam csr_idx_type REG_COEF_A10        = 8'd2;
   localparam csr_idx_type REG_COEF_A11        = 8'd3;
   localparam csr_idx_type REG_OFFSET_C0       = 8'd4;
   localparam csr_idx_type REG_OFFSET_C1       = 8'd5;
   localparam csr_idx_type REG_SPIKE_THRESHOLD = 8'd6;
   localparam csr_idx_type REG_RESET_LEVEL     = 8'd7;

   localparam word_type COEF_DIAG_RST = 32'sd65536;
   localparam word_type ZERO_RST      = 32'sd0;

   typedef struct packed {
      word_type a00;
      word_type a01;
      word_type a10;
      word_type a11;
      word_type c0;
      word_type c1;
      word_type thresh;
      word_type rst_level;
   } cfg_type;

   typedef struct packed {
      id_type   id;
      word_type x0;
      word_type x1;
   } in_stage_type;

   typedef struct packed {
      id_type   id;
      word_type x1;
      prod_type p00;
      prod_type p01;
      prod_type p10;
      prod_type p11;
   } prod_stage_type;

   typedef struct packed {
      id_type   id;
      word_type v0;
      word_type v1;
   } sum_stage_type;

endpackage

>>> rtl/lnut_ifs.sv
// Handshake channel interfaces: neuron request, neuron response and register write.
interface lnut_req_if;
   import lnut_pkg::*;
   logic     valid;
   logic     ready;
   id_type   neuron_id;
   word_type var_zero;
   word_type var_one;

   modport source (output valid, output neuron_id, output var_zero, output var_one,
                   input ready);
   modport sink   (input valid, input neuron_id, input var_zero, input var_one,
                   output ready);
endinterface

interface lnut_rsp_if;
   import lnut_pkg::*;
   logic     valid;
   logic     ready;
   id_type   out_neuron_id;
   word_type new_var_zero;
   word_type new_var_one;
   logic     spiked;

   modport source (output valid, output out_neuron_id, output new_var_zero,
                   output new_var_one, output spiked, input ready);
   modport sink   (input valid, input out_neuron_id, input new_var_zero,
                   input new_var_one, input spiked, output ready);
endinterface

interface lnut_csr_if;
   import lnut_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   word_type    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/lnut_csr.sv
// Configuration register file: coefficients, offsets, threshold and reset level.
module lnut_csr
   import lnut_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lnut_csr_if.sink   csr,
   output cfg_type    cfg
);

   cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.a00       <= COEF_DIAG_RST;
         cfg_ff.a01       <= ZERO_RST;
         cfg_ff.a10       <= ZERO_RST;
         cfg_ff.a11       <= COEF_DIAG_RST;
         cfg_ff.c0        <= ZERO_RST;
         cfg_ff.c1        <= ZERO_RST;
         cfg_ff.thresh    <= ZERO_RST;
         cfg_ff.rst_level <= ZERO_RST;
      end else if (csr.valid) begin
         case (csr.index)
            REG_COEF_A00:        cfg_ff.a00       <= csr.data;
            REG_COEF_A01:        cfg_ff.a01       <= csr.data;
            REG_COEF_A10:        cfg_ff.a10       <= csr.data;
            REG_COEF_A11:        cfg_ff.a11       <= csr.data;
            REG_OFFSET_C0:       cfg_ff.c0        <= csr.data;
            REG_OFFSET_C1:       cfg_ff.c1        <= csr.data;
            REG_SPIKE_THRESHOLD: cfg_ff.thresh    <= csr.data;
            REG_RESET_LEVEL:     cfg_ff.rst_level <= csr.data;
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/lnut_mul.sv
// Input capture stage and product stage: four 32x32 signed coefficient products.
module lnut_mul
   import lnut_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   lnut_req_if.sink       req,
   input  cfg_type        cfg,
   output logic           out_valid,
   input  logic           out_ready,
   output prod_stage_type out_data
);

   logic           s1_valid_ff;
   in_stage_type   s1_data_ff;
   logic           s2_valid_ff;
   prod_stage_type s2_data_ff;
   prod_stage_type s2_data_in;
   logic           s1_ready;
   logic           s2_ready;
   word_type       x0;
   word_type       x1;
   prod_type       p00;
   prod_type       p01;
   prod_type       p10;
   prod_type       p11;

   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;

   assign x0  = s1_data_ff.x0;
   assign x1  = s1_data_ff.x1;
   assign p00 = cfg.a00 * x0;
   assign p01 = cfg.a01 * x1;
   assign p10 = cfg.a10 * x0;
   assign p11 = cfg.a11 * x1;

   always_comb begin
      s2_data_in.id  = s1_data_ff.id;
      s2_data_in.x1  = x1;
      s2_data_in.p00 = p00;
      s2_data_in.p01 = p01;
      s2_data_in.p10 = p10;
      s2_data_in.p11 = p11;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req.valid) begin
         s1_data_ff.id <= req.neuron_id;
         s1_data_ff.x0 <= req.var_zero;
         s1_data_ff.x1 <= req.var_one;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

>>> rtl/lnut_acc.sv
// Sum stage: floor-shift the products, add the offsets and saturate to 32 bits.
module lnut_acc
   import lnut_pkg::*;
#(
   parameter int VAR_COUNT = VAR_COUNT_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           in_valid,
   output logic           in_ready,
   input  prod_stage_type in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output sum_stage_type  out_data
);

   localparam bit       UseB     = (VAR_COUNT >= 2);
   localparam prod_type WORD_MAX = prod_type'(64'sh0000_0000_7FFF_FFFF);
   localparam prod_type WORD_MIN = prod_type'(64'shFFFF_FFFF_8000_0000);

   function automatic word_type sat_word(input prod_type v);
      if (v > WORD_MAX) begin
         return WORD_MAX[WORD_W-1:0];
      end else if (v < WORD_MIN) begin
         return WORD_MIN[WORD_W-1:0];
      end
      return v[WORD_W-1:0];
   endfunction

   logic          valid_ff;
   sum_stage_type data_ff;
   sum_stage_type data_in;
   prod_type      t00;
   prod_type      t01;
   prod_type      t10;
   prod_type      t11;
   prod_type      sum0;
   prod_type      sum1;

   assign in_ready = !valid_ff || out_ready;

   assign t00 = in_data.p00 >>> FRAC_BITS;
   assign t01 = in_data.p01 >>> FRAC_BITS;
   assign t10 = in_data.p10 >>> FRAC_BITS;
   assign t11 = in_data.p11 >>> FRAC_BITS;

   always_comb begin
      sum0 = prod_type'(cfg.c0) + t00 + (UseB ? t01 : '0);
      sum1 = prod_type'(cfg.c1) + t11 + t10;
      data_in.id = in_data.id;
      data_in.v0 = sat_word(sum0);
      data_in.v1 = UseB ? sat_word(sum1) : in_data.x1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/lnut_fire.sv
// Threshold stage: spike test, reset of the spiking variable and output register.
module lnut_fire
   import lnut_pkg::*;
#(
   parameter int SPIKE_VAR = SPIKE_VAR_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  sum_stage_type in_data,
   lnut_rsp_if.source    rsp
);

   localparam bit SpikeSel = ((SPIKE_VAR % 2) != 0);

   logic     valid_ff;
   id_type   id_ff;
   word_type v0_ff;
   word_type v1_ff;
   logic     spiked_ff;
   word_type sel_var;
   logic     spike_in;
   word_type v0_in;
   word_type v1_in;

   assign in_ready = !valid_ff || rsp.ready;

   always_comb begin
      sel_var  = SpikeSel ? in_data.v1 : in_data.v0;
      spike_in = (sel_var > cfg.thresh);
      v0_in    = (spike_in && !SpikeSel) ? cfg.rst_level : in_data.v0;
      v1_in    = (spike_in &&  SpikeSel) ? cfg.rst_level : in_data.v1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         id_ff     <= in_data.id;
         v0_ff     <= v0_in;
         v1_ff     <= v1_in;
         spiked_ff <= spike_in;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.out_neuron_id = id_ff;
   assign rsp.new_var_zero  = v0_ff;
   assign rsp.new_var_one   = v1_ff;
   assign rsp.spiked        = spiked_ff;

endmodule

>>> rtl/linear_neuron_update_threshold_core.sv
// Top level of the linear neuron update pipeline with threshold and reset.
//
// Usage:
//   req_chan carries one neuron per item: its index and two signed Q16.16
//   state variables. rsp_chan returns one item per request, in order: the
//   index, the updated variables and a spike flag. csr_chan writes the eight
//   configuration registers (index 0..7); other indexes are ignored. Writes
//   are always ready and take effect on the next edge; write only while no
//   item is in flight.
// Pipeline and throughput:
//   Four register stages: input capture, products (four 32x32 multipliers),
//   shift/add/saturate, threshold and output register. One item per cycle
//   is sustained while rsp_chan is ready; every stage holds its own item.
// Reset:
//   Synchronous, active high. Empties the pipeline and loads the register
//   defaults (identity matrix, zero offsets, threshold and reset level).
// Stalls:
//   While rsp_chan is not ready the output holds; upstream stages keep
//   filling until full, then req_chan ready drops. Nothing is lost or repeated.
module linear_neuron_update_threshold_core
   import lnut_pkg::*;
#(
   parameter int VAR_COUNT = VAR_COUNT_DEF,
   parameter int SPIKE_VAR = SPIKE_VAR_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   lnut_req_if.sink    req_chan,
   lnut_rsp_if.source  rsp_chan,
   lnut_csr_if.sink    csr_chan
);

   cfg_type        cfg;
   logic           prod_valid;
   logic           prod_ready;
   prod_stage_type prod_data;
   logic           sum_valid;
   logic           sum_ready;
   sum_stage_type  sum_data;

   lnut_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   lnut_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cfg       (cfg),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   lnut_acc #(
      .VAR_COUNT (VAR_COUNT),
      .FRAC_BITS (FRAC_BITS)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   lnut_fire #(
      .SPIKE_VAR (SPIKE_VAR)
   ) u_fire (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (sum_valid),
      .in_ready (sum_ready),
      .in_data  (sum_data),
      .rsp      (rsp_chan)
   );

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the linear neuron update core: directed rows, then random phases.
`timescale 1ns / 1ps

module testbench;
   import lnut_pkg::*;

   localparam int NV = VAR_COUNT_DEF;
   localparam int SV = SPIKE_VAR_DEF % 2;
   localparam int FB = FRAC_BITS_DEF;

   localparam int LATENCY         = 4;
   localparam int N_PHASES        = 8;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int HOLD_CYCLES     = 300;
   localparam int IDLE_LIMIT      = 3000;
   localparam int MAX_PRINTED     = 40;

   localparam word_type    W_MAX = 32'sh7fffffff;
   localparam word_type    W_MIN = 32'sh80000000;
   localparam word_type    W_ONE = 32'sh00010000;
   localparam longint      L_MAX = 64'sd2147483647;
   localparam longint      L_MIN = -64'sd2147483648;
   localparam csr_idx_type REG_UNUSED_FIRST = 8'd8;
   localparam csr_idx_type REG_UNUSED_LAST  = 8'd255;

   typedef struct packed {
      id_type   id;
      word_type v0;
      word_type v1;
      logic     spiked;
   } neuron_update_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              typed;
      csr_idx_type       idx;
      word_type          data;
      id_type            id;
      word_type          x0;
      word_type          x1;
      neuron_update_type want;
   } dir_row_type;

   typedef enum int {SET_NEURON, SET_WILD, SET_MIN, SET_MAX, SET_DEFAULT} setting_kind_type;

   logic clock;
   logic reset;

   lnut_req_if req_chan ();
   lnut_rsp_if rsp_chan ();
   lnut_csr_if csr_chan ();

   linear_neuron_update_threshold_core #(
      .VAR_COUNT (NV),
      .SPIKE_VAR (SPIKE_VAR_DEF),
      .FRAC_BITS (FB)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   neuron_update_type pending_updates [$];
   cfg_type           cfg_mirror;
   csr_idx_type       reg_list [8];

   int  err_count  = 0;
   int  n_items    = 0;
   int  n_checked  = 0;
   int  n_spikes   = 0;
   int  n_writes   = 0;
   bit  req_held   = 0;
   bit  sender_steady = 0;
   bit  rsp_steady    = 0;
   bit  hold_request  = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint scaled(word_type a, word_type x);
      longint p;
      p = longint'($signed(a)) * longint'($signed(x));
      return p >>> FB;
   endfunction

   function automatic word_type clamp32(longint v);
      if (v > L_MAX) return W_MAX;
      if (v < L_MIN) return W_MIN;
      return word_type'(v);
   endfunction

   function automatic neuron_update_type predict_update(cfg_type c, id_type id,
                                                        word_type x0, word_type x1);
      neuron_update_type r;
      longint            acc;
      word_type          v [2];
      acc = longint'($signed(c.c0)) + scaled(c.a00, x0);
      if (NV >= 2) acc += scaled(c.a01, x1);
      v[0] = clamp32(acc);
      if (NV >= 2)
         v[1] = clamp32(longint'($signed(c.c1)) + scaled(c.a11, x1) + scaled(c.a10, x0));
      else
         v[1] = x1;
      r.spiked = ($signed(v[SV]) > $signed(c.thresh));
      if (r.spiked) v[SV] = c.rst_level;
      r.id = id;
      r.v0 = v[0];
      r.v1 = v[1];
      return r;
   endfunction

   function automatic cfg_type cfg_write(cfg_type c, csr_idx_type idx, word_type d);
      case (idx)
         REG_COEF_A00:        c.a00 = d;
         REG_COEF_A01:        c.a01 = d;
         REG_COEF_A10:        c.a10 = d;
         REG_COEF_A11:        c.a11 = d;
         REG_OFFSET_C0:       c.c0 = d;
         REG_OFFSET_C1:       c.c1 = d;
         REG_SPIKE_THRESHOLD: c.thresh = d;
         REG_RESET_LEVEL:     c.rst_level = d;
         default: ;
      endcase
      return c;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return word_type'(int'($urandom_range(0, 262143)) - 131072);
         4, 5, 6:    return word_type'($urandom);
         7:          return W_MAX;
         8:          return W_MIN;
         default:    return word_type'(int'($urandom_range(0, 4)) - 2);
      endcase
   endfunction

   function automatic word_type setting_value(setting_kind_type kind, csr_idx_type idx);
      case (kind)
         SET_WILD: return word_type'($urandom);
         SET_MIN:  return W_MIN;
         SET_MAX:  return W_MAX;
         SET_DEFAULT: begin
            if (idx == REG_COEF_A00 || idx == REG_COEF_A11) return COEF_DIAG_RST;
            return ZERO_RST;
         end
         default: begin
            case (idx)
               REG_COEF_A00, REG_COEF_A11:
                  return word_type'($urandom_range(32768, 65536));
               REG_COEF_A01, REG_COEF_A10:
                  return word_type'(int'($urandom_range(0, 32768)) - 16384);
               REG_OFFSET_C0, REG_OFFSET_C1:
                  return word_type'(int'($urandom_range(0, 16384)) - 4096);
               REG_SPIKE_THRESHOLD:
                  return word_type'($urandom_range(0, 65536));
               default:
                  return word_type'(int'($urandom_range(0, 32768)) - 32768);
            endcase
         end
      endcase
   endfunction

   function automatic dir_row_type item_row(id_type id, word_type x0, word_type x1);
      dir_row_type r;
      r = '0;
      r.kind = ROW_ITEM;
      r.id   = id;
      r.x0   = x0;
      r.x1   = x1;
      return r;
   endfunction

   function automatic dir_row_type typed_row(id_type id, word_type x0, word_type x1,
                                             word_type v0, word_type v1, logic spk);
      dir_row_type r;
      r = item_row(id, x0, x1);
      r.typed       = 1'b1;
      r.want.id     = id;
      r.want.v0     = v0;
      r.want.v1     = v1;
      r.want.spiked = spk;
      return r;
   endfunction

   function automatic dir_row_type csr_row(csr_idx_type idx, word_type d);
      dir_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.idx  = idx;
      r.data = d;
      return r;
   endfunction

   task automatic report_mismatch(string field, id_type id, longint got, longint want);
      err_count++;
      if (err_count <= MAX_PRINTED)
         $display("MISMATCH %s for neuron %0d: got %0h, want %0h", field, id, got, want);
   endtask

   task automatic send_item(id_type id, word_type x0, word_type x1, logic typed,
                            neuron_update_type want);
      int gap;
      req_chan.valid     <= 1'b1;
      req_chan.neuron_id <= id;
      req_chan.var_zero  <= x0;
      req_chan.var_one   <= x1;
      do @(posedge clock); while (!req_chan.ready);
      pending_updates = {pending_updates,
                         (typed ? want : predict_update(cfg_mirror, id, x0, x1))};
      n_items++;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         req_held = 0;
         repeat (gap) @(posedge clock);
      end else begin
         req_held = 1;
      end
   endtask

   task automatic write_reg(csr_idx_type idx, word_type d);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= d;
      do @(posedge clock); while (!csr_chan.ready);
      cfg_mirror = cfg_write(cfg_mirror, idx, d);
      n_writes++;
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      if (req_held) begin
         req_chan.valid <= 1'b0;
         req_held = 0;
      end
      while (pending_updates.size() != 0) @(posedge clock);
   endtask

   task automatic apply_setting(setting_kind_type kind);
      for (int i = 0; i < 8; i++)
         write_reg(reg_list[i], setting_value(kind, reg_list[i]));
   endtask

   // result checker
   always @(posedge clock) begin
      neuron_update_type got;
      neuron_update_type want;
      if (rsp_chan.valid && rsp_chan.ready) begin
         got.id     = rsp_chan.out_neuron_id;
         got.v0     = rsp_chan.new_var_zero;
         got.v1     = rsp_chan.new_var_one;
         got.spiked = rsp_chan.spiked;
         if (pending_updates.size() == 0) begin
            report_mismatch("unexpected item", got.id, 0, 0);
         end else begin
            want = pending_updates.pop_front();
            n_checked++;
            if (got.spiked) n_spikes++;
            if (got.id !== want.id)
               report_mismatch("out_neuron_id", want.id, got.id, want.id);
            if (got.v0 !== want.v0)
               report_mismatch("new_var_zero", want.id, got.v0, want.v0);
            if (got.v1 !== want.v1)
               report_mismatch("new_var_one", want.id, got.v1, want.v1);
            if (got.spiked !== want.spiked)
               report_mismatch("spiked", want.id, got.spiked, want.spiked);
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      int idle_cycles;
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // response ready
   initial begin
      int n;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 0;
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else begin
            n = rsp_steady ? 0 : pick_gap();
            if (n > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin
      dir_row_type      dir_rows [$];
      dir_row_type      row;
      setting_kind_type kind;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.neuron_id = '0;
      req_chan.var_zero  = '0;
      req_chan.var_one   = '0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = '0;
      csr_chan.data      = '0;

      cfg_mirror.a00       = COEF_DIAG_RST;
      cfg_mirror.a01       = ZERO_RST;
      cfg_mirror.a10       = ZERO_RST;
      cfg_mirror.a11       = COEF_DIAG_RST;
      cfg_mirror.c0        = ZERO_RST;
      cfg_mirror.c1        = ZERO_RST;
      cfg_mirror.thresh    = ZERO_RST;
      cfg_mirror.rst_level = ZERO_RST;

      reg_list[0] = REG_COEF_A00;
      reg_list[1] = REG_COEF_A01;
      reg_list[2] = REG_COEF_A10;
      reg_list[3] = REG_COEF_A11;
      reg_list[4] = REG_OFFSET_C0;
      reg_list[5] = REG_OFFSET_C1;
      reg_list[6] = REG_SPIKE_THRESHOLD;
      reg_list[7] = REG_RESET_LEVEL;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity matrix after reset: state passes through, positive variable 0 spikes
      dir_rows = {dir_rows, typed_row(10'd0, 0, 0, 0, 0, 1'b0)};
      dir_rows = {dir_rows, typed_row(10'd1023, W_MAX, W_MAX, ZERO_RST, W_MAX, 1'b1)};
      dir_rows = {dir_rows, typed_row(10'h155, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0)};
      dir_rows = {dir_rows, typed_row(10'h2aa, 1, -1, ZERO_RST, -1, 1'b1)};
      dir_rows = {dir_rows, typed_row(10'd3, -1, 32'sh12345678, -1, 32'sh12345678, 1'b0)};
      // writes to unused indexes must leave the identity in place
      dir_rows = {dir_rows, csr_row(REG_UNUSED_FIRST, W_MAX)};
      dir_rows = {dir_rows, csr_row(REG_UNUSED_LAST, W_MIN)};
      dir_rows = {dir_rows, typed_row(10'd7, W_ONE, 5, ZERO_RST, 5, 1'b1)};
      // extreme coefficients: sums saturate at both limits
      dir_rows = {dir_rows, csr_row(REG_COEF_A00, W_MAX)};
      dir_rows = {dir_rows, csr_row(REG_COEF_A01, W_MAX)};
      dir_rows = {dir_rows, csr_row(REG_COEF_A10, W_MIN)};
      dir_rows = {dir_rows, csr_row(REG_COEF_A11, W_MIN)};
      dir_rows = {dir_rows, csr_row(REG_OFFSET_C0, W_MAX)};
      dir_rows = {dir_rows, csr_row(REG_OFFSET_C1, W_MIN)};
      dir_rows = {dir_rows, csr_row(REG_SPIKE_THRESHOLD, W_MAX)};
      dir_rows = {dir_rows, csr_row(REG_RESET_LEVEL, W_MIN)};
      dir_rows = {dir_rows, item_row(10'h3ff, W_MAX, W_MAX)};
      dir_rows = {dir_rows, item_row(10'h000, W_MIN, W_MIN)};
      dir_rows = {dir_rows, item_row(10'h200, W_MAX, W_MIN)};
      dir_rows = {dir_rows, item_row(10'h001, 0, 0)};
      dir_rows = {dir_rows, csr_row(REG_SPIKE_THRESHOLD, W_MIN)};
      dir_rows = {dir_rows, item_row(10'h0f0, 0, 0)};
      dir_rows = {dir_rows, item_row(10'h00f, W_MIN, W_MAX)};

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_reg(row.idx, row.data);
         end else begin
            send_item(row.id, row.x0, row.x1, row.typed, row.want);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         case (p)
            0:       kind = SET_MAX;
            1:       kind = SET_MIN;
            2:       kind = SET_DEFAULT;
            default: kind = ($urandom_range(0, 3) == 0) ? SET_WILD : SET_NEURON;
         endcase
         apply_setting(kind);
         if ($urandom_range(0, 2) == 0)
            write_reg(csr_idx_type'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                      word_type'($urandom));
         sender_steady = (p == 3 || p == 4);
         rsp_steady    = (p == 3);
         if (p == 4) hold_request = 1;
         repeat (ITEMS_PER_PHASE)
            send_item(id_type'($urandom_range(0, 1023)), pick_word(), pick_word(), 1'b0, '0);
      end

      wait_idle();
      repeat (LATENCY + 4) @(posedge clock);

      $display("Covered %0d neuron updates (%0d spiking) with %0d register writes.",
               n_items, n_spikes, n_writes);
      $display("Included saturation at both limits, ignored indexes and a %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches over %0d checked results", err_count, n_checked);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
